@@ hw/rtl/four_key_debounce_hold_repeat_defines.svh @@
// Assertion macros used by the key lane RTL.
`ifndef FOUR_KEY_DEBOUNCE_HOLD_REPEAT_DEFINES_SVH
`define FOUR_KEY_DEBOUNCE_HOLD_REPEAT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FKDHR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fkdhr assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FKDHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fkdhr assertion failed");

`endif

@@ hw/rtl/fkdhr_pkg.sv @@
// Package: constants and types of the four-key debounce/hold/repeat block.
package fkdhr_pkg;

  localparam int unsigned KEY_COUNT   = 4;
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned CFG_WIDTH   = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PIN_WIDTH   = 8;

  localparam logic [COUNT_WIDTH-1:0] CNT_SAT = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

  // key phase codes
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
  localparam logic [1:0] PH_CONFIRMED = 2'd2;
  localparam logic [1:0] PH_RELEASE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TEST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MEM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_EARCAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REP_EN      = 3'd6;

  localparam logic [COUNT_WIDTH-1:0] HOLD_RST     = 8'd150;
  localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RST = 8'd3;
  localparam logic [COUNT_WIDTH-1:0] GAP_RST      = 8'd10;

  // per-key flags
  typedef struct packed {
    logic press;
    logic hold;
    logic rep;
    logic rel;
  } fkdhr_flags_t;

  // per-key scan controls
  typedef struct packed {
    logic tick;
    logic down;
    logic rel_ack;
    logic hld_ack;
    logic clr;
  } fkdhr_tick_t;

  // per-key settings
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] hold_cnt;
    logic [COUNT_WIDTH-1:0] dbc;
    logic [COUNT_WIDTH-1:0] gap;
    logic                   rep_en;
  } fkdhr_lcfg_t;

endpackage

@@ hw/rtl/fkdhr_ifs.sv @@
// Valid/ready channel interfaces for scan ticks and flag results.
interface fkdhr_in_if;
  import fkdhr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIN_WIDTH-1:0] port_pins;
  logic                 earcap_pin;
  logic [KEY_COUNT-1:0] release_ack;
  logic [KEY_COUNT-1:0] hold_ack;
  logic                 clear_all;

  modport source (output valid, port_pins, earcap_pin, release_ack, hold_ack, clear_all,
                  input ready);
  modport sink (input valid, port_pins, earcap_pin, release_ack, hold_ack, clear_all,
                output ready);
endinterface

interface fkdhr_out_if;
  import fkdhr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_COUNT-1:0] press_flags;
  logic [KEY_COUNT-1:0] hold_flags;
  logic [KEY_COUNT-1:0] repeat_flags;
  logic [KEY_COUNT-1:0] release_flags;

  modport source (output valid, press_flags, hold_flags, repeat_flags, release_flags,
                  input ready);
  modport sink (input valid, press_flags, hold_flags, repeat_flags, release_flags,
                output ready);
endinterface

@@ hw/rtl/fkdhr_lane.sv @@
// One key lane: phase machine, hold counter and the key's four flags.
`include "four_key_debounce_hold_repeat_defines.svh"

module fkdhr_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fkdhr_pkg::fkdhr_tick_t tick_i,
  input  fkdhr_pkg::fkdhr_lcfg_t cfg_i,
  output fkdhr_pkg::fkdhr_flags_t flags_o
);
  import fkdhr_pkg::*;

  logic [1:0]             phase_q, phase_d, phase_a;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_a, cnt_inc, cnt_c;
  fkdhr_flags_t           flags_q, flags_d, flags_a;

  always_comb begin
    // acknowledges and clear come first
    flags_a     = flags_q;
    flags_a.rel = flags_q.rel & ~tick_i.rel_ack;
    flags_a.hold = flags_q.hold & ~tick_i.hld_ack;
    cnt_a       = tick_i.hld_ack ? '0 : cnt_q;
    phase_a     = phase_q;
    if (tick_i.clr) begin
      flags_a = '0;
      phase_a = PH_IDLE;
    end

    cnt_inc = cnt_a + 1'b1;
    cnt_c   = (cnt_a < CNT_SAT) ? cnt_inc : cnt_a;

    phase_d = phase_a;
    cnt_d   = cnt_a;
    flags_d = flags_a;
    unique case (phase_a)
      PH_IDLE: begin
        if (tick_i.down) begin
          cnt_d   = '0;
          phase_d = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (tick_i.down) begin
          cnt_d = cnt_inc;
          if (cnt_inc > cfg_i.dbc) begin
            phase_d       = PH_CONFIRMED;
            flags_d.press = 1'b1;
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_CONFIRMED: begin
        if (tick_i.down) begin
          cnt_d = cnt_c;
          if (cnt_c > cfg_i.hold_cnt) begin
            flags_d.hold = 1'b1;
            if (cfg_i.rep_en) begin
              flags_d.rep = 1'b1;
              cnt_d       = cfg_i.hold_cnt - cfg_i.gap;
            end
          end
        end else begin
          phase_d = PH_RELEASE;
        end
      end
      default: begin
        if (!tick_i.down) begin
          flags_d.press = 1'b0;
          flags_d.hold  = 1'b0;
          flags_d.rep   = 1'b0;
          flags_d.rel   = 1'b1;
          phase_d       = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      flags_q <= '0;
    end else if (tick_i.tick) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

  `FKDHR_ASSERT(a_no_press_unconfirmed, phase_q == PH_IDLE || phase_q == PH_DEBOUNCE, !flags_q.press)
  `FKDHR_ASSERT(a_hold_needs_press, flags_q.hold, flags_q.press)
  `FKDHR_ASSERT(a_rep_needs_press, flags_q.rep, flags_q.press)
  `FKDHR_ASSERT_NEXT(a_clr_to_idle, tick_i.tick && tick_i.clr && !tick_i.down, phase_q == PH_IDLE)

endmodule

@@ hw/rtl/fkdhr_merge.sv @@
// Merge stage: gathers lane flags into result masks and runs the output handshake.
module fkdhr_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  fkdhr_in_if.sink                in_i,
  fkdhr_out_if.source             out_o,
  input  fkdhr_pkg::fkdhr_flags_t flags_i [fkdhr_pkg::KEY_COUNT],
  output logic                    tick_o
);
  import fkdhr_pkg::*;

  logic out_valid_q, out_valid_d;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign tick_o      = in_i.valid && in_i.ready;
  assign out_valid_d = tick_o || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < KEY_COUNT; k++) begin
      out_o.press_flags[k]   = flags_i[k].press;
      out_o.hold_flags[k]    = flags_i[k].hold;
      out_o.repeat_flags[k]  = flags_i[k].rep;
      out_o.release_flags[k] = flags_i[k].rel;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

@@ hw/rtl/four_key_debounce_hold_repeat.sv @@
// Four-key debouncer with long-press and auto-repeat flags. One scan tick
// is one input transaction; the block takes one every clock cycle and shows
// the four flag masks (state after that tick) on the output channel in the
// next cycle. Each key runs in its own lane with a registered update of its
// phase and counter, and the lane flag registers double as the output
// register, so a new tick is taken in the same cycle a waiting result is
// consumed. When the output is stalled, input ready drops. Configuration
// writes are registered and must be made while no result is pending.
module four_key_debounce_hold_repeat (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fkdhr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fkdhr_pkg::CFG_WIDTH-1:0]    cfg_wdata_i,
  fkdhr_in_if.sink                           in_i,
  fkdhr_out_if.source                        out_o
);
  import fkdhr_pkg::*;

  // configuration registers
  logic [COUNT_WIDTH-1:0] hold_cnt_q [KEY_COUNT];
  logic [COUNT_WIDTH-1:0] dbc_q;
  logic [COUNT_WIDTH-1:0] gap_q;
  logic [KEY_COUNT-1:0]   rep_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < KEY_COUNT; k++) begin
        hold_cnt_q[k] <= HOLD_RST;
      end
      dbc_q    <= DEBOUNCE_RST;
      gap_q    <= GAP_RST;
      rep_en_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLD_SET:    hold_cnt_q[0] <= cfg_wdata_i;
        REG_HOLD_TEST:   hold_cnt_q[1] <= cfg_wdata_i;
        REG_HOLD_MEM:    hold_cnt_q[2] <= cfg_wdata_i;
        REG_HOLD_EARCAP: hold_cnt_q[3] <= cfg_wdata_i;
        REG_DEBOUNCE:    dbc_q         <= cfg_wdata_i;
        REG_GAP:         gap_q         <= cfg_wdata_i;
        REG_REP_EN:      rep_en_q      <= cfg_wdata_i[KEY_COUNT-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // pin decode: set, test, mem on port bits 0, 1, 4; earcap on its own pin.
  // all active low.
  logic [KEY_COUNT-1:0] down;
  assign down = {~in_i.earcap_pin, ~in_i.port_pins[4], ~in_i.port_pins[1],
                 ~in_i.port_pins[0]};

  logic         tick;
  fkdhr_tick_t  lane_tick  [KEY_COUNT];
  fkdhr_lcfg_t  lane_cfg   [KEY_COUNT];
  fkdhr_flags_t lane_flags [KEY_COUNT];

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    always_comb begin
      lane_tick[k].tick    = tick;
      lane_tick[k].down    = down[k];
      lane_tick[k].rel_ack = in_i.release_ack[k];
      lane_tick[k].hld_ack = in_i.hold_ack[k];
      lane_tick[k].clr     = in_i.clear_all;
      lane_cfg[k].hold_cnt = hold_cnt_q[k];
      lane_cfg[k].dbc      = dbc_q;
      lane_cfg[k].gap      = gap_q;
      lane_cfg[k].rep_en   = rep_en_q[k];
    end

    fkdhr_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tick_i  (lane_tick[k]),
      .cfg_i   (lane_cfg[k]),
      .flags_o (lane_flags[k])
    );
  end

  // combine lane flags into the four result masks
  fkdhr_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .flags_i (lane_flags),
    .tick_o  (tick)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the four-key debounce / hold / auto-repeat block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fkdhr_pkg::*;

  // Port bits that carry the active-low set, test and mem keys.
  localparam int SET_PIN  = 0;
  localparam int TEST_PIN = 1;
  localparam int MEM_PIN  = 4;

  // Unused register index; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // No transaction on either channel for this many cycles means the block hung.
  localparam int STALL_LIMIT = 2000;

  // One scan tick as sent to the block.
  typedef struct packed {
    logic [PIN_WIDTH-1:0] port_pins;
    logic                 earcap_pin;
    logic [KEY_COUNT-1:0] release_ack;
    logic [KEY_COUNT-1:0] hold_ack;
    logic                 clear_all;
  } scan_tick_t;

  // The four flag masks after one tick.
  typedef struct packed {
    logic [KEY_COUNT-1:0] press;
    logic [KEY_COUNT-1:0] hold;
    logic [KEY_COUNT-1:0] rpt;
    logic [KEY_COUNT-1:0] rel;
  } key_flags_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_WIDTH-1:0] cfg_wdata_i;

  fkdhr_in_if  tick_if ();
  fkdhr_out_if flags_if ();

  four_key_debounce_hold_repeat dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_if),
    .out_o       (flags_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: settings, per-key lanes and the four flag masks.
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] hold_limit [KEY_COUNT];
  logic [COUNT_WIDTH-1:0] debounce_limit;
  logic [COUNT_WIDTH-1:0] reload_gap;
  logic [KEY_COUNT-1:0]   auto_repeat;

  logic [1:0]             lane_phase [KEY_COUNT];
  logic [COUNT_WIDTH-1:0] lane_count [KEY_COUNT];
  logic [KEY_COUNT-1:0]   pressed_keys, held_keys, repeating_keys, released_keys;

  // Flag masks predicted for ticks already taken, oldest first.
  key_flags_t expected_flags_q[$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Key levels are active low; earcap sits on its own pin.
  function automatic logic key_pressed(int k, scan_tick_t t);
    case (k)
      0:       return !t.port_pins[SET_PIN];
      1:       return !t.port_pins[TEST_PIN];
      2:       return !t.port_pins[MEM_PIN];
      default: return !t.earcap_pin;
    endcase
  endfunction

  // Advances the shadow by one tick and returns the masks the block should show.
  function automatic key_flags_t scan_keys(scan_tick_t t);
    key_flags_t f;
    logic       down;
    // acknowledges first, then clear-all, then the key scan
    released_keys &= ~t.release_ack;
    held_keys     &= ~t.hold_ack;
    for (int k = 0; k < KEY_COUNT; k++)
      if (t.hold_ack[k]) lane_count[k] = '0;
    if (t.clear_all) begin
      pressed_keys   = '0;
      held_keys      = '0;
      repeating_keys = '0;
      released_keys  = '0;
      // counters are kept; entering debounce zeroes them anyway
      for (int k = 0; k < KEY_COUNT; k++) lane_phase[k] = PH_IDLE;
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      down = key_pressed(k, t);
      case (lane_phase[k])
        PH_IDLE: begin
          if (down) begin
            lane_count[k] = '0;
            lane_phase[k] = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (down) begin
            lane_count[k] = lane_count[k] + 1'b1;  // wraps at the counter width
            if (lane_count[k] > debounce_limit) begin
              lane_phase[k]   = PH_CONFIRMED;
              pressed_keys[k] = 1'b1;
            end
          end else begin
            lane_phase[k] = PH_IDLE;
          end
        end
        PH_CONFIRMED: begin
          if (down) begin
            if (lane_count[k] < CNT_SAT) lane_count[k] = lane_count[k] + 1'b1;
            if (lane_count[k] > hold_limit[k]) begin
              held_keys[k] = 1'b1;
              if (auto_repeat[k]) begin
                repeating_keys[k] = 1'b1;
                lane_count[k]     = hold_limit[k] - reload_gap;  // modular step back
              end
            end
          end else begin
            lane_phase[k] = PH_RELEASE;
          end
        end
        default: begin
          // a key pressed again here stays put until it reads released
          if (!down) begin
            held_keys[k]      = 1'b0;
            pressed_keys[k]   = 1'b0;
            repeating_keys[k] = 1'b0;
            released_keys[k]  = 1'b1;
            lane_phase[k]     = PH_IDLE;
          end
        end
      endcase
    end
    f.press = pressed_keys;
    f.hold  = held_keys;
    f.rpt   = repeating_keys;
    f.rel   = released_keys;
    return f;
  endfunction

  function automatic scan_tick_t mk_tick(logic [PIN_WIDTH-1:0] port, logic ear,
                                         logic [KEY_COUNT-1:0] rel_ack,
                                         logic [KEY_COUNT-1:0] hld_ack, logic clr);
    scan_tick_t t;
    t.port_pins   = port;
    t.earcap_pin  = ear;
    t.release_ack = rel_ack;
    t.hold_ack    = hld_ack;
    t.clear_all   = clr;
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; handshakes are sampled on
  // the rising edge. Each task is entered and left on a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one tick, with random idle cycles ahead of it, and records its result.
  task automatic send_tick(input scan_tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.port_pins   <= t.port_pins;
    tick_if.earcap_pin  <= t.earcap_pin;
    tick_if.release_ack <= t.release_ack;
    tick_if.hold_ack    <= t.hold_ack;
    tick_if.clear_all   <= t.clear_all;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    expected_flags_q.push_back(scan_keys(t));
    @(negedge clk_i);
  endtask

  // Settings change only with no tick in flight and nothing left to drain.
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_HOLD_SET:    hold_limit[0]  = val;
      REG_HOLD_TEST:   hold_limit[1]  = val;
      REG_HOLD_MEM:    hold_limit[2]  = val;
      REG_HOLD_EARCAP: hold_limit[3]  = val;
      REG_DEBOUNCE:    debounce_limit = val;
      REG_GAP:         reload_gap     = val;
      REG_REP_EN:      auto_repeat    = val[KEY_COUNT-1:0];
      default: ;  // unused index: ignored
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] h_set, input logic [7:0] h_test,
                               input logic [7:0] h_mem, input logic [7:0] h_ear,
                               input logic [7:0] dbc, input logic [7:0] gap,
                               input logic [3:0] rep_en);
    set_reg(REG_HOLD_SET, h_set);
    set_reg(REG_HOLD_TEST, h_test);
    set_reg(REG_HOLD_MEM, h_mem);
    set_reg(REG_HOLD_EARCAP, h_ear);
    set_reg(REG_DEBOUNCE, dbc);
    set_reg(REG_GAP, gap);
    set_reg(REG_REP_EN, {4'h0, rep_en});
  endtask

  // Key traffic as press/release runs per key. Held runs last up to max_hold
  // ticks, released runs are short, with short bounces and single-tick glitches
  // mixed in. hold_ack comes about once in ack_odds ticks, clear_all once in 5 * ack_odds.
  task automatic run_key_traffic(input int n, input int max_hold, input int ack_odds);
    logic [KEY_COUNT-1:0] down;
    logic [KEY_COUNT-1:0] level;
    int                   run_left [KEY_COUNT];
    scan_tick_t           t;
    down = '0;
    for (int k = 0; k < KEY_COUNT; k++) run_left[k] = 0;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (run_left[k] == 0) begin
          down[k] = ~down[k];
          if ($urandom_range(9) == 0) run_left[k] = $urandom_range(1, 2);
          else if (down[k])           run_left[k] = $urandom_range(1, max_hold);
          else                        run_left[k] = $urandom_range(1, 8);
        end
        run_left[k]--;
      end
      level = down;
      if ($urandom_range(19) == 0) level ^= KEY_COUNT'($urandom_range(15));
      t.port_pins           = PIN_WIDTH'($urandom_range(255));
      t.port_pins[SET_PIN]  = ~level[0];
      t.port_pins[TEST_PIN] = ~level[1];
      t.port_pins[MEM_PIN]  = ~level[2];
      t.earcap_pin          = ~level[3];
      t.release_ack = ($urandom_range(3) == 0) ? KEY_COUNT'($urandom_range(15)) : '0;
      t.hold_ack    = ($urandom_range(ack_odds - 1) == 0) ?
                      KEY_COUNT'($urandom_range(15)) : '0;
      t.clear_all   = ($urandom_range(5 * ack_odds - 1) == 0);
      send_tick(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked ticks: all keys, acknowledges, clear-all and the release corner.
  task automatic test_directed();
    send_idle_pct = 36;
    recv_idle_pct = 82;
    wait_idle();
    load_settings(8'd2, 8'd0, 8'd1, 8'd4, 8'd1, 8'd3, 4'b0110);
    set_reg(REG_UNUSED, 8'hFF);  // must leave every setting alone
    send_tick(mk_tick(8'hFF, 1'b1, 4'h0, 4'h0, 1'b0));  // all released
    for (int i = 0; i < 7; i++)                          // all held: debounce, hold, repeat
      send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b0));
    send_tick(mk_tick(8'hEC, 1'b0, 4'h0, 4'hF, 1'b0));  // hold ack while held
    send_tick(mk_tick(8'hEC, 1'b0, 4'h0, 4'h0, 1'b0));
    send_tick(mk_tick(8'hFF, 1'b1, 4'h0, 4'h0, 1'b0));  // into release phase
    send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b0));  // pressed again: stays in release
    send_tick(mk_tick(8'hFF, 1'b1, 4'h0, 4'h0, 1'b0));  // sticky release flags
    send_tick(mk_tick(8'hFF, 1'b1, 4'b0101, 4'h0, 1'b0));
    send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b0));
    send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b0));
    send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b1));  // clear-all while held
    send_tick(mk_tick(8'h00, 1'b0, 4'h0, 4'h0, 1'b0));
    send_tick(mk_tick(8'hFF, 1'b1, 4'hF, 4'h0, 1'b0));
    send_tick(mk_tick(8'h13, 1'b1, 4'h0, 4'h0, 1'b0));  // keys up, other bits low
    send_tick(mk_tick(8'hEC, 1'b0, 4'hF, 4'hF, 1'b1));  // every control at once
    send_tick(mk_tick(8'hFF, 1'b1, 4'h0, 4'h0, 1'b0));
  endtask

  // Small random hold and debounce settings, any gap, busy acknowledge traffic.
  task automatic test_random_mixed();
    send_idle_pct = 36;
    recv_idle_pct = 82;
    wait_idle();
    load_settings(8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                  8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                  8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)));
    run_key_traffic(300, 60, 10);
  endtask

  // Largest debounce, extreme hold counts and a wrapping reload, long presses.
  task automatic test_random_extremes();
    send_idle_pct = 82;
    recv_idle_pct = 36;
    wait_idle();
    load_settings(8'd254, 8'd0, 8'd200, 8'd254, 8'd254, 8'd255, 4'hF);
    run_key_traffic(350, 320, 400);
  endtask

  // No idling: instant confirm, saturating counter on set, repeat every tick.
  task automatic test_random_fast();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    load_settings(8'd254, 8'd0, 8'd1, 8'd3, 8'd0, 8'd0, 4'b1010);
    run_key_traffic(330, 300, 40);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, the checker and the watchdog.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i)
    flags_if.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    key_flags_t got, want;
    if (rst_ni && flags_if.valid && flags_if.ready) begin
      got.press = flags_if.press_flags;
      got.hold  = flags_if.hold_flags;
      got.rpt   = flags_if.repeat_flags;
      got.rel   = flags_if.release_flags;
      if (expected_flags_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        want = expected_flags_q.pop_front();
        if (got.press !== want.press)
          report_mismatch($sformatf("press_flags %h, want %h", got.press, want.press));
        if (got.hold !== want.hold)
          report_mismatch($sformatf("hold_flags %h, want %h", got.hold, want.hold));
        if (got.rpt !== want.rpt)
          report_mismatch($sformatf("repeat_flags %h, want %h", got.rpt, want.rpt));
        if (got.rel !== want.rel)
          report_mismatch($sformatf("release_flags %h, want %h", got.rel, want.rel));
      end
    end
    // any transaction on either channel counts as progress
    if ((tick_if.valid && tick_if.ready) || (flags_if.valid && flags_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    stall_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    tick_if.valid       = 1'b0;
    tick_if.port_pins   = '1;
    tick_if.earcap_pin  = 1'b1;
    tick_if.release_ack = '0;
    tick_if.hold_ack    = '0;
    tick_if.clear_all   = 1'b0;
    flags_if.ready      = 1'b0;

    // shadow starts from the reset values
    for (int k = 0; k < KEY_COUNT; k++) begin
      hold_limit[k] = HOLD_RST;
      lane_phase[k] = PH_IDLE;
      lane_count[k] = '0;
    end
    debounce_limit = DEBOUNCE_RST;
    reload_gap     = GAP_RST;
    auto_repeat    = '0;
    pressed_keys   = '0;
    held_keys      = '0;
    repeating_keys = '0;
    released_keys  = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_mixed();
    test_random_extremes();
    test_random_fast();

    // drain, then wait out anything stray
    wait_idle();
    repeat (4) @(negedge clk_i);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fkdhr_pkg.sv
hw/rtl/fkdhr_ifs.sv
hw/rtl/fkdhr_lane.sv
hw/rtl/fkdhr_merge.sv
hw/rtl/four_key_debounce_hold_repeat.sv
bench/testbench.sv
